// ===== hdl/ssm_pkg.sv =====
// ssm_pkg: shared types, codes and constants for the scanline segment merge
// used by every module of the block; depends on nothing

package ssm_pkg;

   // fixed field widths
   localparam int LEN_W        = 11;
   localparam int POS_W        = 10;
   localparam int EXT_W        = 12;
   localparam int STAT_W       = 3;
   localparam int PHASE_W      = 3;
   localparam int PORT_COLOR_W = 16;
   localparam int NUM_COLORS   = 6;

   // default colour precision
   localparam int DEF_COLOR_BITS = 16;

   // reset value of the scanline width register and position saturation
   localparam logic [LEN_W-1:0] WIDTH_RESET = 11'd1024;
   localparam logic [LEN_W-1:0] POS_SAT     = 11'h7FF;

   // merge phases
   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_BEFORE = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_AFTER  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DONE   = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
   localparam logic [STAT_W-1:0] ST_BEFORE = 3'd1;
   localparam logic [STAT_W-1:0] ST_HEAD   = 3'd2;
   localparam logic [STAT_W-1:0] ST_SPAN   = 3'd3;
   localparam logic [STAT_W-1:0] ST_TAIL   = 3'd4;
   localparam logic [STAT_W-1:0] ST_AFTER  = 3'd5;

   // result kinds and opcodes
   localparam logic KIND_SEG = 1'b0;
   localparam logic KIND_SUM = 1'b1;
   localparam logic OP_LOAD  = 1'b0;

   // colour order: red, green, blue start then red, green, blue end
   typedef struct packed {
      logic                                      is_load;
      logic [POS_W-1:0]                          start_pixel;
      logic [LEN_W-1:0]                          capacity;
      logic [LEN_W-1:0]                          seg_length;
      logic [NUM_COLORS-1:0][PORT_COLOR_W-1:0]   color;
      logic                                      last_old;
   } ssm_item_type;

   typedef struct packed {
      logic                                      kind;
      logic [LEN_W-1:0]                          out_length;
      logic [NUM_COLORS-1:0][PORT_COLOR_W-1:0]   color;
      logic [STAT_W-1:0]                         status;
      logic [LEN_W-1:0]                          total_segments;
      logic                                      final_flag;
   } ssm_rsp_type;

   // interpolation unit status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } ssm_iu_stat_type;

endpackage

// ===== hdl/scanline_segment_merge_top.sv =====
// scanline_segment_merge_top: front queue, merge sequencer and interpolation unit
// uses ssm_pkg, ssm_front, ssm_interp and ssm_back
// requests wait in the two-entry front queue while the sequencer works, and stall once it is full
// each clipped cut runs through the shared bit-serial divider, which works at the colour
// precision (16-bit colour by default)
// reset: synchronous; queue empty, merge idle, scanline width 1024, span state zero

module scanline_segment_merge_top import ssm_pkg::*; #(
   parameter int COLOR_BITS = DEF_COLOR_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [LEN_W-1:0]          csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_opcode,
   input  logic [POS_W-1:0]          req_start_pixel,
   input  logic [LEN_W-1:0]          req_capacity,
   input  logic [LEN_W-1:0]          req_seg_length,
   input  logic [PORT_COLOR_W-1:0]   req_red_start,
   input  logic [PORT_COLOR_W-1:0]   req_green_start,
   input  logic [PORT_COLOR_W-1:0]   req_blue_start,
   input  logic [PORT_COLOR_W-1:0]   req_red_end,
   input  logic [PORT_COLOR_W-1:0]   req_green_end,
   input  logic [PORT_COLOR_W-1:0]   req_blue_end,
   input  logic                      req_last_old,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_kind,
   output logic [LEN_W-1:0]          rsp_out_length,
   output logic [PORT_COLOR_W-1:0]   rsp_out_red_start,
   output logic [PORT_COLOR_W-1:0]   rsp_out_green_start,
   output logic [PORT_COLOR_W-1:0]   rsp_out_blue_start,
   output logic [PORT_COLOR_W-1:0]   rsp_out_red_end,
   output logic [PORT_COLOR_W-1:0]   rsp_out_green_end,
   output logic [PORT_COLOR_W-1:0]   rsp_out_blue_end,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [LEN_W-1:0]          rsp_total_segments,
   output logic                      rsp_final_flag
);

   localparam int CW = (COLOR_BITS < PORT_COLOR_W) ? COLOR_BITS : PORT_COLOR_W;

   logic                  head_valid, pop, iu_start;
   ssm_item_type          head;
   logic [2:0][CW-1:0]    iu_a, iu_b, iu_res;
   logic [LEN_W-1:0]      iu_k, iu_len;
   ssm_iu_stat_type       iu_stat;
   ssm_rsp_type           rsp;

   // front: accept and queue
   ssm_front #(.CW(CW)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_start_pixel(req_start_pixel),
      .req_capacity(req_capacity), .req_seg_length(req_seg_length),
      .req_red_start(req_red_start), .req_green_start(req_green_start),
      .req_blue_start(req_blue_start), .req_red_end(req_red_end),
      .req_green_end(req_green_end), .req_blue_end(req_blue_end),
      .req_last_old(req_last_old),
      .head_valid(head_valid), .head(head), .pop(pop)
   );

   // shared interpolation unit
   ssm_interp #(.CW(CW)) u_interp (
      .clock(clock), .reset(reset), .start(iu_start),
      .a_val(iu_a), .b_val(iu_b), .k_val(iu_k), .len_val(iu_len),
      .stat(iu_stat), .result(iu_res)
   );

   // back: merge sequencer and result register
   ssm_back #(.CW(CW)) u_back (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .head_valid(head_valid), .head(head), .pop(pop),
      .iu_start(iu_start), .iu_a(iu_a), .iu_b(iu_b), .iu_k(iu_k), .iu_len(iu_len),
      .iu_stat(iu_stat), .iu_res(iu_res),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   // result fields
   assign rsp_kind            = rsp.kind;
   assign rsp_out_length      = rsp.out_length;
   assign rsp_out_red_start   = rsp.color[0];
   assign rsp_out_green_start = rsp.color[1];
   assign rsp_out_blue_start  = rsp.color[2];
   assign rsp_out_red_end     = rsp.color[3];
   assign rsp_out_green_end   = rsp.color[4];
   assign rsp_out_blue_end    = rsp.color[5];
   assign rsp_status          = rsp.status;
   assign rsp_total_segments  = rsp.total_segments;
   assign rsp_final_flag      = rsp.final_flag;

endmodule

// ===== hdl/ssm_interp.sv =====
// ssm_interp: three-lane linear interpolation a +/- |b-a|*k/len
// a multiply on start, then a shared restoring divide sequence; uses ssm_pkg

module ssm_interp import ssm_pkg::*; #(
   parameter int CW = DEF_COLOR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0][CW-1:0]    a_val,
   input  logic [2:0][CW-1:0]    b_val,
   input  logic [LEN_W-1:0]      k_val,
   input  logic [LEN_W-1:0]      len_val,
   output ssm_iu_stat_type       stat,
   output logic [2:0][CW-1:0]    result
);

   localparam int CNT_W  = $clog2(CW);
   localparam int PROD_W = CW + LEN_W;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [2:0][CW-1:0]      a_ff, a_in;
   logic [2:0]              up_ff, up_in;
   logic [2:0][LEN_W-1:0]   rem_ff, rem_in;
   logic [2:0][CW-1:0]      sh_ff, sh_in;

   logic [CW-1:0]           diff;
   logic [PROD_W-1:0]       prod;
   logic [LEN_W:0]          trial;
   logic                    ge;

   // start: multiply, then one quotient bit per lane each cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      len_in  = len_ff;
      a_in    = a_ff;
      up_in   = up_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      diff    = '0;
      prod    = '0;
      trial   = '0;
      ge      = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         len_in  = len_val;
         for (int i = 0; i < 3; i++) begin
            a_in[i]  = a_val[i];
            up_in[i] = (b_val[i] >= a_val[i]);
            diff     = up_in[i] ? (b_val[i] - a_val[i]) : (a_val[i] - b_val[i]);
            prod     = PROD_W'(diff) * PROD_W'(k_val);
            rem_in[i] = prod[PROD_W-1:CW];
            sh_in[i]  = prod[CW-1:0];
         end
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            trial     = {rem_ff[i], sh_ff[i][CW-1]};
            ge        = (trial >= {1'b0, len_ff});
            rem_in[i] = ge ? LEN_W'(trial - {1'b0, len_ff}) : trial[LEN_W-1:0];
            sh_in[i]  = {sh_ff[i][CW-2:0], ge};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // quotient applied in the direction of the gradient
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         result[i] = up_ff[i] ? (a_ff[i] + sh_ff[i]) : (a_ff[i] - sh_ff[i]);
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      a_ff   <= a_in;
      up_ff  <= up_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

endmodule

// ===== hdl/ssm_front.sv =====
// ssm_front: accepts request transfers, classifies and masks them into a
// two-entry queue toward the sequencer; uses ssm_pkg

module ssm_front import ssm_pkg::*; #(
   parameter int CW = DEF_COLOR_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_opcode,
   input  logic [POS_W-1:0]          req_start_pixel,
   input  logic [LEN_W-1:0]          req_capacity,
   input  logic [LEN_W-1:0]          req_seg_length,
   input  logic [PORT_COLOR_W-1:0]   req_red_start,
   input  logic [PORT_COLOR_W-1:0]   req_green_start,
   input  logic [PORT_COLOR_W-1:0]   req_blue_start,
   input  logic [PORT_COLOR_W-1:0]   req_red_end,
   input  logic [PORT_COLOR_W-1:0]   req_green_end,
   input  logic [PORT_COLOR_W-1:0]   req_blue_end,
   input  logic                      req_last_old,
   output logic                      head_valid,
   output ssm_item_type              head,
   input  logic                      pop
);

   localparam logic [PORT_COLOR_W-1:0] CMASK = PORT_COLOR_W'((1 << CW) - 1);

   ssm_item_type    entry_ff [2];
   ssm_item_type    item;
   logic            wr_ptr_ff, rd_ptr_ff;
   logic [1:0]      cnt_ff, cnt_in;
   logic            push;

   // classify and mask the incoming item
   always_comb begin
      item.is_load     = (req_opcode == OP_LOAD);
      item.start_pixel = req_start_pixel;
      item.capacity    = req_capacity;
      item.seg_length  = req_seg_length;
      item.color[0]    = req_red_start & CMASK;
      item.color[1]    = req_green_start & CMASK;
      item.color[2]    = req_blue_start & CMASK;
      item.color[3]    = req_red_end & CMASK;
      item.color[4]    = req_green_end & CMASK;
      item.color[5]    = req_blue_end & CMASK;
      item.last_old    = req_last_old;
   end

   assign req_stall  = (cnt_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== hdl/ssm_back.sv =====
// ssm_back: merge sequencer, span state, width register and result register
// drives the interpolation unit; uses ssm_pkg

module ssm_back import ssm_pkg::*; #(
   parameter int CW = DEF_COLOR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [LEN_W-1:0]      csr_write_data,
   input  logic                  head_valid,
   input  ssm_item_type          head,
   output logic                  pop,
   output logic                  iu_start,
   output logic [2:0][CW-1:0]    iu_a,
   output logic [2:0][CW-1:0]    iu_b,
   output logic [LEN_W-1:0]      iu_k,
   output logic [LEN_W-1:0]      iu_len,
   input  ssm_iu_stat_type       iu_stat,
   input  logic [2:0][CW-1:0]    iu_res,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ssm_rsp_type           rsp
);

   // sequencer states
   localparam logic [3:0] SQ_IDLE      = 4'd0;
   localparam logic [3:0] SQ_BEFORE    = 4'd1;
   localparam logic [3:0] SQ_HEAD_WAIT = 4'd2;
   localparam logic [3:0] SQ_HEAD_EMIT = 4'd3;
   localparam logic [3:0] SQ_SPAN      = 4'd4;
   localparam logic [3:0] SQ_SKIP      = 4'd5;
   localparam logic [3:0] SQ_TAIL_WAIT = 4'd6;
   localparam logic [3:0] SQ_TAIL_EMIT = 4'd7;
   localparam logic [3:0] SQ_AFTER     = 4'd8;
   localparam logic [3:0] SQ_END       = 4'd9;
   localparam logic [3:0] SQ_END_SPAN  = 4'd10;
   localparam logic [3:0] SQ_SUM       = 4'd11;

   logic [3:0]                   sq_ff, sq_in;
   logic [PHASE_W-1:0]           phase_ff, phase_in;
   logic [LEN_W-1:0]             width_ff, width_in;
   logic [LEN_W-1:0]             old_pos_ff, old_pos_in;
   logic [LEN_W-1:0]             emitted_ff, emitted_in;
   logic [LEN_W-1:0]             cap_ff, cap_in;
   logic [LEN_W-1:0]             slen_ff, slen_in;
   logic [POS_W-1:0]             sstart_ff, sstart_in;
   logic [NUM_COLORS-1:0][CW-1:0] span_col_ff, span_col_in;
   ssm_item_type                 cur_ff, cur_in;
   logic [EXT_W-1:0]             p_ff, p_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ssm_rsp_type                  rsp_ff, rsp_in;

   logic [EXT_W-1:0]             old_ext, last_px, s_ext, e_ext, width_ext;
   logic                         p_same, out_free, cap_ok;
   logic                         em_req, em_sum;
   logic [LEN_W-1:0]             em_len;
   logic [NUM_COLORS-1:0][CW-1:0] em_col, cur_col;
   logic [STAT_W-1:0]            em_code;

   // positions of the current segment and of the span
   always_comb begin
      old_ext   = {1'b0, old_pos_ff};
      last_px   = old_ext + {1'b0, cur_ff.seg_length};
      s_ext     = {2'b0, sstart_ff};
      e_ext     = s_ext + {1'b0, slen_ff};
      width_ext = {1'b0, width_ff};
      p_same    = (p_ff == old_ext);
      out_free  = !rsp_valid_ff || !rsp_stall;
      cap_ok    = (emitted_ff < cap_ff);
      for (int i = 0; i < NUM_COLORS; i++) begin
         cur_col[i] = cur_ff.color[i][CW-1:0];
      end
   end

   // interpolation operands come from the current old segment
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         iu_a[i] = cur_col[i];
         iu_b[i] = cur_col[3 + i];
      end
      iu_len = cur_ff.seg_length;
   end

   // sequencer
   always_comb begin
      sq_in        = sq_ff;
      phase_in     = phase_ff;
      width_in     = csr_write_enable ? csr_write_data : width_ff;
      old_pos_in   = old_pos_ff;
      emitted_in   = emitted_ff;
      cap_in       = cap_ff;
      slen_in      = slen_ff;
      sstart_in    = sstart_ff;
      span_col_in  = span_col_ff;
      cur_in       = cur_ff;
      p_in         = p_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      iu_start     = 1'b0;
      iu_k         = '0;
      em_req       = 1'b0;
      em_sum       = 1'b0;
      em_len       = '0;
      em_col       = '0;
      em_code      = ST_OK;

      unique case (sq_ff)
         SQ_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head;
               if (head.is_load) begin
                  for (int i = 0; i < NUM_COLORS; i++) begin
                     span_col_in[i] = head.color[i][CW-1:0];
                  end
                  slen_in    = head.seg_length;
                  sstart_in  = head.start_pixel;
                  cap_in     = head.capacity;
                  old_pos_in = '0;
                  emitted_in = '0;
                  if (head.seg_length == '0) begin
                     phase_in = PH_DONE;
                     sq_in    = SQ_SUM;
                  end else begin
                     phase_in = PH_BEFORE;
                  end
               end else if (phase_ff == PH_BEFORE || phase_ff == PH_SKIP ||
                            phase_ff == PH_AFTER) begin
                  p_in  = old_ext;
                  sq_in = (phase_ff == PH_BEFORE) ? SQ_BEFORE : SQ_SKIP;
               end
            end
         end
         SQ_BEFORE: begin
            if (last_px <= s_ext) begin
               em_req  = 1'b1;
               em_len  = cur_ff.seg_length;
               em_col  = cur_col;
               em_code = ST_BEFORE;
               if (out_free && cap_ok) begin
                  p_in  = last_px;
                  sq_in = SQ_SKIP;
               end
            end else if (p_ff < s_ext) begin
               iu_start = 1'b1;
               iu_k     = LEN_W'(s_ext - p_ff);
               sq_in    = SQ_HEAD_WAIT;
            end else begin
               sq_in = SQ_SPAN;
            end
         end
         SQ_HEAD_WAIT: begin
            if (iu_stat.done) begin
               sq_in = SQ_HEAD_EMIT;
            end
         end
         SQ_HEAD_EMIT: begin
            em_req  = 1'b1;
            em_len  = LEN_W'(s_ext - p_ff);
            for (int i = 0; i < 3; i++) begin
               em_col[i]     = cur_col[i];
               em_col[3 + i] = iu_res[i];
            end
            em_code = ST_HEAD;
            if (out_free && cap_ok) begin
               sq_in = SQ_SPAN;
            end
         end
         SQ_SPAN, SQ_END_SPAN: begin
            em_req  = 1'b1;
            em_len  = slen_ff;
            em_col  = span_col_ff;
            em_code = ST_SPAN;
            if (out_free && cap_ok) begin
               if (sq_ff == SQ_SPAN) begin
                  phase_in = PH_SKIP;
                  sq_in    = SQ_SKIP;
               end else begin
                  sq_in = SQ_SUM;
               end
            end
         end
         SQ_SKIP: begin
            sq_in = SQ_AFTER;
            if (phase_ff == PH_SKIP && p_same) begin
               if (p_ff < e_ext && last_px <= e_ext) begin
                  p_in = last_px;
               end else if (p_ff < e_ext) begin
                  iu_start = 1'b1;
                  iu_k     = LEN_W'(e_ext - p_ff);
                  sq_in    = SQ_TAIL_WAIT;
               end else begin
                  phase_in = PH_AFTER;
               end
            end
         end
         SQ_TAIL_WAIT: begin
            if (iu_stat.done) begin
               sq_in = SQ_TAIL_EMIT;
            end
         end
         SQ_TAIL_EMIT: begin
            em_req  = 1'b1;
            em_len  = LEN_W'(last_px - e_ext);
            for (int i = 0; i < 3; i++) begin
               em_col[i]     = iu_res[i];
               em_col[3 + i] = cur_col[3 + i];
            end
            em_code = ST_TAIL;
            if (out_free && cap_ok) begin
               p_in     = last_px;
               phase_in = PH_AFTER;
               sq_in    = SQ_AFTER;
            end
         end
         SQ_AFTER: begin
            if (phase_ff == PH_AFTER && p_same && p_ff < width_ext) begin
               em_req  = 1'b1;
               em_len  = cur_ff.seg_length;
               em_col  = cur_col;
               em_code = ST_AFTER;
               if (out_free && cap_ok) begin
                  p_in  = last_px;
                  sq_in = SQ_END;
               end
            end else begin
               sq_in = SQ_END;
            end
         end
         SQ_END: begin
            old_pos_in = (p_ff > {1'b0, POS_SAT}) ? POS_SAT : p_ff[LEN_W-1:0];
            if (p_ff >= width_ext || cur_ff.last_old) begin
               sq_in = (phase_ff == PH_BEFORE) ? SQ_END_SPAN : SQ_SUM;
            end else begin
               sq_in = SQ_IDLE;
            end
         end
         SQ_SUM: begin
            em_req = 1'b1;
            em_sum = 1'b1;
            if (out_free) begin
               phase_in = PH_DONE;
               sq_in    = SQ_IDLE;
            end
         end
         default: begin
            sq_in = SQ_IDLE;
         end
      endcase

      // result register load: segment, summary or out-of-space summary
      if (em_req && out_free) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_length  = '0;
         rsp_in.color       = '0;
         rsp_in.total_segments = '0;
         if (em_sum) begin
            rsp_in.kind           = KIND_SUM;
            rsp_in.status         = ST_OK;
            rsp_in.total_segments = emitted_ff;
            rsp_in.final_flag     = 1'b1;
         end else if (cap_ok) begin
            rsp_in.kind       = KIND_SEG;
            rsp_in.out_length = em_len;
            for (int i = 0; i < NUM_COLORS; i++) begin
               rsp_in.color[i] = PORT_COLOR_W'(em_col[i]);
            end
            rsp_in.status     = ST_OK;
            rsp_in.final_flag = 1'b0;
            emitted_in        = emitted_ff + 1'b1;
         end else begin
            rsp_in.kind       = KIND_SUM;
            rsp_in.status     = em_code;
            rsp_in.final_flag = 1'b1;
            phase_in          = PH_DONE;
            sq_in             = SQ_IDLE;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff        <= SQ_IDLE;
         phase_ff     <= PH_IDLE;
         width_ff     <= WIDTH_RESET;
         old_pos_ff   <= '0;
         emitted_ff   <= '0;
         cap_ff       <= '0;
         slen_ff      <= '0;
         sstart_ff    <= '0;
         span_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_ff        <= sq_in;
         phase_ff     <= phase_in;
         width_ff     <= width_in;
         old_pos_ff   <= old_pos_in;
         emitted_ff   <= emitted_in;
         cap_ff       <= cap_in;
         slen_ff      <= slen_in;
         sstart_ff    <= sstart_in;
         span_col_ff  <= span_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      p_ff   <= p_in;
      rsp_ff <= rsp_in;
   end

   // count of emitted segments never passes the capacity
   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= cap_ff)
      else $error("emitted segment count above capacity");

   // a wait state always has the interpolation unit working or finishing
   a_iu_wait: assert property (@(posedge clock) disable iff (reset)
      (sq_ff == SQ_HEAD_WAIT || sq_ff == SQ_TAIL_WAIT) |-> (iu_stat.busy || iu_stat.done))
      else $error("waiting on an idle interpolation unit");

   // any summary closes the merge
   a_sum_done: assert property (@(posedge clock) disable iff (reset)
      (em_req && out_free && (em_sum || !cap_ok)) |=> (phase_ff == PH_DONE))
      else $error("summary sent without ending the merge");

endmodule

// ===== tb/sv/scanline_segment_merge_top_test.sv =====
// scanline_segment_merge_top_test: self-checking bench for the scanline segment merge
// drives a directed table then random merges, predicts every result and compares
// depends on ssm_pkg and scanline_segment_merge_top
`timescale 1ns / 100ps

module scanline_segment_merge_top_test;
   import ssm_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   // merge phases of the predictor
   typedef enum logic [2:0] {
      M_IDLE, M_BEFORE, M_SKIP, M_AFTER, M_DONE
   } merge_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [LEN_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   ssm_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ssm_rsp_type got;

   always #6 clock = ~clock;

   scanline_segment_merge_top u_top (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(~req_item.is_load), .req_start_pixel(req_item.start_pixel),
      .req_capacity(req_item.capacity), .req_seg_length(req_item.seg_length),
      .req_red_start(req_item.color[0]), .req_green_start(req_item.color[1]),
      .req_blue_start(req_item.color[2]), .req_red_end(req_item.color[3]),
      .req_green_end(req_item.color[4]), .req_blue_end(req_item.color[5]),
      .req_last_old(req_item.last_old),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(got.kind), .rsp_out_length(got.out_length),
      .rsp_out_red_start(got.color[0]), .rsp_out_green_start(got.color[1]),
      .rsp_out_blue_start(got.color[2]), .rsp_out_red_end(got.color[3]),
      .rsp_out_green_end(got.color[4]), .rsp_out_blue_end(got.color[5]),
      .rsp_status(got.status), .rsp_total_segments(got.total_segments),
      .rsp_final_flag(got.final_flag)
   );

   // predictor state
   logic [LEN_W-1:0] line_width;
   logic [LEN_W-1:0] cur_pos;
   logic [LEN_W-1:0] emit_count;
   logic [LEN_W-1:0] cap_limit;
   logic [LEN_W-1:0] span_len;
   logic [POS_W-1:0] span_start;
   logic [NUM_COLORS-1:0][PORT_COLOR_W-1:0] span_color;
   merge_phase_type phase;

   ssm_rsp_type expected_rsp[$];
   int fail_count = 0;
   int cycle_count = 0;
   bit hold_rsp = 1'b0;

   function automatic logic [15:0] lerp(logic [15:0] a, logic [15:0] b,
                                        logic [11:0] k, logic [11:0] len);
      logic [31:0] prod;
      if (len == 0) return a;
      if (b >= a) begin
         prod = 32'(b - a) * k;
         return a + 16'(prod / len);
      end
      prod = 32'(a - b) * k;
      return a - 16'(prod / len);
   endfunction

   // push one segment or the error summary; returns 0 when the merge stops
   function automatic bit push_seg(logic [LEN_W-1:0] len,
                                   logic [NUM_COLORS-1:0][PORT_COLOR_W-1:0] col,
                                   logic [STAT_W-1:0] code);
      ssm_rsp_type r;
      r = '0;
      if (emit_count >= cap_limit) begin
         phase = M_DONE;
         r.kind = KIND_SUM; r.status = code; r.final_flag = 1'b1;
         expected_rsp.push_back(r);
         return 1'b0;
      end
      r.kind = KIND_SEG; r.out_length = len; r.color = col;
      expected_rsp.push_back(r);
      emit_count++;
      return 1'b1;
   endfunction

   function automatic void push_summary(logic [LEN_W-1:0] total);
      ssm_rsp_type r;
      r = '0;
      r.kind = KIND_SUM; r.final_flag = 1'b1; r.total_segments = total;
      expected_rsp.push_back(r);
   endfunction

   // work out the results one accepted transfer causes
   function automatic void predict_merge(ssm_item_type it);
      logic [11:0] p, len, last_px, s, e, k;
      logic [NUM_COLORS-1:0][PORT_COLOR_W-1:0] cut;
      if (it.is_load) begin
         span_color = it.color; span_len = it.seg_length;
         span_start = it.start_pixel; cap_limit = it.capacity;
         cur_pos = '0; emit_count = '0;
         if (it.seg_length == 0) begin
            phase = M_DONE;
            push_summary('0);
         end else phase = M_BEFORE;
         return;
      end
      if (phase == M_IDLE || phase == M_DONE) return;
      p = 12'(cur_pos); len = 12'(it.seg_length); last_px = p + len;
      s = 12'(span_start); e = s + 12'(span_len);
      if (phase == M_BEFORE) begin
         if (last_px <= s) begin
            if (!push_seg(LEN_W'(len), it.color, ST_BEFORE)) return;
            p = last_px;
         end else begin
            if (p < s) begin
               k = s - p;
               for (int i = 0; i < 3; i++) begin
                  cut[i] = it.color[i];
                  cut[3+i] = lerp(it.color[i], it.color[3+i], k, len);
               end
               if (!push_seg(LEN_W'(k), cut, ST_HEAD)) return;
            end
            if (!push_seg(span_len, span_color, ST_SPAN)) return;
            phase = M_SKIP;
         end
      end
      if (phase == M_SKIP && p == 12'(cur_pos)) begin
         if (p < e && last_px <= e) p = last_px;
         else if (p < e) begin
            k = e - p;
            for (int i = 0; i < 3; i++) begin
               cut[i] = lerp(it.color[i], it.color[3+i], k, len);
               cut[3+i] = it.color[3+i];
            end
            if (!push_seg(LEN_W'(len - k), cut, ST_TAIL)) return;
            p = last_px;
            phase = M_AFTER;
         end else phase = M_AFTER;
      end
      if (phase == M_AFTER && p == 12'(cur_pos) && p < 12'(line_width)) begin
         if (!push_seg(LEN_W'(len), it.color, ST_AFTER)) return;
         p = last_px;
      end
      cur_pos = (p > 12'(POS_SAT)) ? POS_SAT : LEN_W'(p);
      if (p >= 12'(line_width) || it.last_old) begin
         if (phase == M_BEFORE)
            if (!push_seg(span_len, span_color, ST_SPAN)) return;
         phase = M_DONE;
         push_summary(emit_count);
      end
   endfunction

   // directed table; rows with a typed expectation are checked on the spot as well
   typedef struct {
      ssm_item_type it;
      bit has_exp;
      ssm_rsp_type exp;
   } table_row_type;
   table_row_type table_rows[$];

   function automatic ssm_item_type mk_load(int sp, int cap, int len,
                                            logic [95:0] col);
      ssm_item_type it;
      it = '0; it.is_load = 1'b1; it.start_pixel = POS_W'(sp); it.capacity = LEN_W'(cap);
      it.seg_length = LEN_W'(len); it.color = col;
      return it;
   endfunction

   function automatic ssm_item_type mk_old(int len, logic [95:0] col, bit last);
      ssm_item_type it;
      it = '0; it.seg_length = LEN_W'(len); it.color = col; it.last_old = last;
      return it;
   endfunction

   function automatic void add_row(ssm_item_type it);
      table_row_type r;
      r.it = it; r.has_exp = 1'b0; r.exp = '0;
      table_rows.push_back(r);
   endfunction

   function automatic ssm_item_type rand_colors(ssm_item_type it);
      for (int i = 0; i < NUM_COLORS; i++) begin
         case ($urandom_range(0, 3))
            0: it.color[i] = 16'h0000;
            1: it.color[i] = 16'hFFFF;
            default: it.color[i] = 16'($urandom);
         endcase
      end
      return it;
   endfunction

   // checking of every result transfer
   always @(posedge clock) begin
      ssm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result transfer kind=%0d", got.kind);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (got.kind !== want.kind) begin
               $error("kind exp %0d got %0d", want.kind, got.kind); fail_count++;
            end
            if (got.out_length !== want.out_length) begin
               $error("out_length exp %0d got %0d", want.out_length, got.out_length);
               fail_count++;
            end
            for (int i = 0; i < NUM_COLORS; i++)
               if (got.color[i] !== want.color[i]) begin
                  $error("color[%0d] exp %h got %h", i, want.color[i], got.color[i]);
                  fail_count++;
               end
            if (got.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, got.status); fail_count++;
            end
            if (got.total_segments !== want.total_segments) begin
               $error("total_segments exp %0d got %0d", want.total_segments,
                      got.total_segments);
               fail_count++;
            end
            if (got.final_flag !== want.final_flag) begin
               $error("final_flag exp %0d got %0d", want.final_flag, got.final_flag);
               fail_count++;
            end
         end
      end
   end

   // receiver stall: random per transfer, or a long hold-off on request
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (gap != 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!(rsp_valid && !rsp_stall));
            rsp_stall <= 1'b0;
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // send one item with a random lead gap, predict on the transfer
   task automatic send_item(ssm_item_type it, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_merge(it);
   endtask

   // drop valid after the last transfer before any wait
   task automatic req_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_and_settle();
      req_idle();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_width(logic [LEN_W-1:0] w);
      csr_write_data <= w;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      line_width = w;
   endtask

   task automatic random_merge(int max_len);
      ssm_item_type it;
      int n_old;
      it = rand_colors('0);
      it.is_load = 1'b1;
      it.start_pixel = POS_W'($urandom_range(0, 60));
      it.seg_length = ($urandom_range(0, 9) == 0) ? '0
                                                  : LEN_W'($urandom_range(1, max_len));
      it.capacity = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 4))
                                                : LEN_W'($urandom_range(5, 1024));
      if ($urandom_range(0, 20) == 0) begin
         it.start_pixel = 10'd1023; it.capacity = 11'd1024;
      end
      send_item(it, 1'b0);
      n_old = $urandom_range(1, 6);
      for (int j = 0; j < n_old; j++) begin
         it = rand_colors('0);
         it.seg_length = ($urandom_range(0, 12) == 0) ? '0
                                                      : LEN_W'($urandom_range(1, max_len));
         if ($urandom_range(0, 30) == 0) it.seg_length = 11'd1024;
         it.last_old = (j == n_old - 1) ? 1'($urandom_range(0, 1))
                                        : ($urandom_range(0, 9) == 0);
         it.start_pixel = POS_W'($urandom);
         it.capacity = LEN_W'($urandom);
         send_item(it, 1'b0);
      end
   endtask

   initial begin
      line_width = WIDTH_RESET;
      cur_pos = '0; emit_count = '0; cap_limit = '0; span_len = '0;
      span_start = '0; span_color = '0; phase = M_IDLE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: idle ignore, zero span, extremes, clips, capacity errors
      add_row(mk_old(5, '1, 1'b1));
      add_row(mk_load(0, 0, 0, '0));
      table_rows[$].has_exp = 1'b1;
      table_rows[$].exp = '{kind: KIND_SUM, final_flag: 1'b1, default: '0};
      add_row(mk_old(3, '0, 1'b1));
      add_row(mk_load(4, 8, 6, {16'h1234, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000}));
      add_row(mk_old(2, {16'hFFFF, 16'h0, 16'h1111, 16'h0, 16'hFFFF, 16'h2222}, 1'b0));
      add_row(mk_old(5, {16'h0, 16'hFFFF, 16'h4000, 16'hFFFF, 16'h0, 16'hC000}, 1'b0));
      add_row(mk_old(2, '1, 1'b0));
      add_row(mk_old(7, {16'h0100, 16'h0200, 16'h0300, 16'hF000, 16'h0001, 16'h7777}, 1'b0));
      add_row(mk_old(1024, '1, 1'b0));
      add_row(mk_load(1023, 1024, 1024, '1));
      add_row(mk_old(1024, '0, 1'b0));
      add_row(mk_load(2, 0, 3, '1));
      table_rows[$].has_exp = 1'b0;
      add_row(mk_old(1, '1, 1'b0));
      table_rows[$].has_exp = 1'b1;
      table_rows[$].exp = '{kind: KIND_SUM, status: ST_BEFORE, final_flag: 1'b1,
                            default: '0};
      add_row(mk_load(0, 1, 3, '0));
      add_row(mk_old(2, '1, 1'b0));
      add_row(mk_old(4, '1, 1'b0));
      add_row(mk_load(1, 1, 2, '0));
      add_row(mk_old(1, '1, 1'b0));
      add_row(mk_load(0, 3, 4, '1));
      add_row(mk_old(0, '1, 1'b0));
      add_row(mk_old(3, '0, 1'b1));
      add_row(mk_load(10, 5, 2, '0));
      add_row(mk_old(3, '1, 1'b1));

      foreach (table_rows[i]) begin
         if (table_rows[i].has_exp) begin
            req_idle();
            while (expected_rsp.size() != 0) @(posedge clock);
            send_item(table_rows[i].it, 1'b0);
            if (expected_rsp.size() == 0 || expected_rsp[0] !== table_rows[i].exp) begin
               $error("table row %0d: expected result %p", i, table_rows[i].exp);
               fail_count++;
            end
         end else send_item(table_rows[i].it, 1'b0);
      end
      drain_and_settle();

      // random merges under several widths, extremes included
      write_width(11'd1);
      for (int m = 0; m < 2; m++) random_merge(8);
      drain_and_settle();
      write_width(11'd40);
      for (int m = 0; m < 4; m++) random_merge(16);
      drain_and_settle();

      // long receiver hold-off while the sender keeps going
      hold_rsp = 1'b1;
      for (int m = 0; m < 4; m++) begin
         ssm_item_type it;
         it = mk_load(0, 1024, 2, '1);
         send_item(it, 1'b1);
         for (int j = 0; j < 4; j++) begin
            it = rand_colors(mk_old(1, '0, 1'b0));
            send_item(it, 1'b1);
         end
      end
      drain_and_settle();

      write_width(11'($urandom_range(2, 2047)));
      for (int m = 0; m < 4; m++) random_merge(30);
      drain_and_settle();
      write_width(11'd2047);
      for (int m = 0; m < 5; m++) random_merge(300);
      drain_and_settle();

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== scanline_segment_merge_top.f =====
hdl/ssm_pkg.sv
hdl/ssm_interp.sv
hdl/ssm_front.sv
hdl/ssm_back.sv
hdl/scanline_segment_merge_top.sv
tb/sv/scanline_segment_merge_top_test.sv
